// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

    // Request modes
    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_RESIZE = 2'd2
    } mode_t;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

    // Granule and header size in bytes
    localparam int unsigned GRAN_BYTES = 8;
    localparam int unsigned HDR_BYTES  = 8;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AL_RD,
        S_AL_CHK,
        S_AL_W2,
        S_FR_RD,
        S_FR_CHK,
        S_FR_MRG,
        S_RS_RD,
        S_RS_CHK,
        S_RS_NX,
        S_DONE
    } state_t;

endpackage

// File: hw/rtl/ffha_hdr_ram.sv
`timescale 1ns / 1ps
module ffha_hdr_ram #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned IW    = 13,
    parameter int unsigned HW    = 18
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [HW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_idx,
    output logic [HW-1:0] rd_data
);

    logic [HW-1:0] mem [DEPTH];
    logic [HW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// First-fit heap allocator over a heap of HEAP_BYTES bytes in 8-byte granules.
// Input channel (in_valid / in_stall) carries one request item: mode
// (allocate, free, resize), request_size and block_addr. Output channel
// (out_valid / out_stall) returns one result item per request: result_addr,
// status and moved. A moved resize leaves the payload copy to the requester.
// Block headers live in one synchronous RAM with a registered read port;
// every header visit passes a read state and a check state. An allocate walks
// blocks first-fit and may split one; a free may merge with the next block; a
// resize grows in place, else does an allocate walk and a free when it moves.
// One request is worked at a time; the next is taken once the result sits in
// the output register, which holds it while out_stall is high. A held result
// keeps the sequencer from finishing the next request until it is taken.
// After reset the block clears the header RAM, one entry per cycle, holding
// in_stall high; the heap then is one free block spanning it.
module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [16:0] request_size,
    input  logic [15:0] block_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_addr,
    output logic [1:0]  status,
    output logic        moved
);
    import ffha_pkg::*;

    localparam int unsigned NHDR = HEAP_BYTES / GRAN_BYTES;
    localparam int unsigned IW   = $clog2(NHDR);
    localparam int unsigned SW   = $clog2(HEAP_BYTES + 1);
    localparam int unsigned HW   = SW + 1;
    localparam int unsigned LW   = ($clog2(HEAP_BYTES) > 17) ? $clog2(HEAP_BYTES) : 17;
    localparam int unsigned W    = LW + 2;
    localparam int unsigned HEAP_TOP = (HEAP_BYTES / 8) * 8;
    localparam logic [W-1:0] TOP_W  = W'(HEAP_TOP);
    localparam logic [W-1:0] HEAP_W = W'(HEAP_BYTES);
    localparam logic [W-1:0] HDR_W  = W'(HDR_BYTES);
    localparam logic [W-1:0] SPLIT_W = W'(HDR_BYTES + GRAN_BYTES);

    function automatic logic [IW-1:0] to_idx(input logic [W-1:0] p);
        logic [W-1:0] q;
        q = (p >> 3) - W'(1);
        return q[IW-1:0];
    endfunction

    function automatic logic [HW-1:0] pack_hdr(input logic [W-1:0] sz, input logic used);
        return {sz[SW-1:0], used};
    endfunction

    state_t        state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [W-1:0]  ptr_reg, ptr_next;
    logic [W-1:0]  blk_reg, blk_next;
    logic [W-1:0]  size_reg, size_next;
    logic [W-1:0]  need_reg, need_next;
    logic [W-1:0]  sz_reg, sz_next;
    logic          mv_reg, mv_next;
    logic [W-1:0]  res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          res_mv_reg, res_mv_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_addr_reg, out_addr_next;
    logic [1:0]    out_st_reg, out_st_next;
    logic          out_mv_reg, out_mv_next;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [HW-1:0] wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic [HW-1:0] rd_data;

    logic [W-1:0]  in_blk;
    logic [W-1:0]  in_size;
    logic [W-1:0]  in_need;
    logic          in_addr_ok;
    logic [W-1:0]  rd_sz;
    logic          rd_used;
    logic [W-1:0]  nx;
    logic [W-1:0]  comb_sz;

    ffha_hdr_ram #(
        .DEPTH (NHDR),
        .IW    (IW),
        .HW    (HW)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    // Decode request and header fields
    assign in_blk     = W'(block_addr);
    assign in_size    = W'(request_size);
    assign in_need    = (in_size + W'(7)) & ~W'(7);
    assign in_addr_ok = (in_blk >= HDR_W) && (in_blk < HEAP_W) && (in_blk[2:0] == 3'd0);
    assign rd_sz      = W'(rd_data[HW-1:1]);
    assign rd_used    = rd_data[0];
    assign nx         = ptr_reg + rd_sz + HDR_W;
    assign comb_sz    = sz_reg + HDR_W + rd_sz;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_addr = out_addr_reg;
    assign status      = out_st_reg;
    assign moved       = out_mv_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            mv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            mv_reg        <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        blk_reg      <= blk_next;
        size_reg     <= size_next;
        need_reg     <= need_next;
        sz_reg       <= sz_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        res_mv_reg   <= res_mv_next;
        out_addr_reg <= out_addr_next;
        out_st_reg   <= out_st_next;
        out_mv_reg   <= out_mv_next;
    end

    // Sequencer: walk, split, free and merge headers
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        blk_next       = blk_reg;
        size_next      = size_reg;
        need_next      = need_reg;
        sz_next        = sz_reg;
        mv_next        = mv_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        res_mv_next    = res_mv_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_st_next    = out_st_reg;
        out_mv_next    = out_mv_reg;
        wr_en          = 1'b0;
        wr_idx         = to_idx(ptr_reg);
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_idx         = to_idx(ptr_reg);

        // Drop a delivered result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_idx  = clr_reg;
                wr_data = (clr_reg == '0) ? pack_hdr(TOP_W - HDR_W, 1'b0) : '0;
                if (clr_reg == IW'(NHDR - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    blk_next      = in_blk;
                    size_next     = in_size;
                    need_next     = in_need;
                    ptr_next      = in_blk;
                    mv_next       = 1'b0;
                    res_addr_next = '0;
                    res_st_next   = ST_NULL;
                    res_mv_next   = 1'b0;
                    state_next    = S_DONE;
                    if (mode == MODE_ALLOC || (mode == MODE_RESIZE && in_blk == '0))
                    begin
                        if (in_size != '0)
                        begin
                            ptr_next   = HDR_W;
                            state_next = S_AL_RD;
                        end
                    end
                    else if (mode == MODE_FREE)
                    begin
                        if (in_addr_ok)
                        begin
                            state_next = S_FR_RD;
                        end
                    end
                    else if (mode == MODE_RESIZE)
                    begin
                        if (!in_addr_ok)
                        begin
                            res_st_next = ST_OOM;
                        end
                        else if (in_size == '0)
                        begin
                            state_next = S_FR_RD;
                        end
                        else
                        begin
                            state_next = S_RS_RD;
                        end
                    end
                end
            end

            S_AL_RD:
            begin
                if (ptr_reg >= TOP_W)
                begin
                    res_addr_next = '0;
                    res_st_next   = ST_OOM;
                    state_next    = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_AL_CHK;
                end
            end

            S_AL_CHK:
            begin
                if (!rd_used && rd_sz >= need_reg)
                begin
                    if (rd_sz >= need_reg + SPLIT_W)
                    begin
                        // Split off the remainder as a free block
                        wr_en      = 1'b1;
                        wr_idx     = to_idx(ptr_reg + need_reg + HDR_W);
                        wr_data    = pack_hdr(rd_sz - need_reg - HDR_W, 1'b0);
                        state_next = S_AL_W2;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data       = pack_hdr(rd_sz, 1'b1);
                        res_addr_next = ptr_reg;
                        res_st_next   = ST_OK;
                        if (mv_reg)
                        begin
                            res_mv_next = 1'b1;
                            ptr_next    = blk_reg;
                            state_next  = S_FR_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    ptr_next   = nx;
                    state_next = S_AL_RD;
                end
            end

            S_AL_W2:
            begin
                wr_en         = 1'b1;
                wr_data       = pack_hdr(need_reg, 1'b1);
                res_addr_next = ptr_reg;
                res_st_next   = ST_OK;
                if (mv_reg)
                begin
                    res_mv_next = 1'b1;
                    ptr_next    = blk_reg;
                    state_next  = S_FR_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FR_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FR_CHK;
            end

            S_FR_CHK:
            begin
                sz_next = rd_sz;
                wr_en   = 1'b1;
                wr_data = pack_hdr(rd_sz, 1'b0);
                if (nx < TOP_W)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = to_idx(nx);
                    state_next = S_FR_MRG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FR_MRG:
            begin
                // Merge with a free next block
                if (!rd_used)
                begin
                    wr_en   = 1'b1;
                    wr_data = pack_hdr(comb_sz, 1'b0);
                end
                state_next = S_DONE;
            end

            S_RS_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_RS_CHK;
            end

            S_RS_CHK:
            begin
                sz_next = rd_sz;
                if (rd_sz >= size_reg)
                begin
                    res_addr_next = blk_reg;
                    res_st_next   = ST_OK;
                    state_next    = S_DONE;
                end
                else if (nx < TOP_W)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = to_idx(nx);
                    state_next = S_RS_NX;
                end
                else
                begin
                    mv_next    = 1'b1;
                    ptr_next   = HDR_W;
                    state_next = S_AL_RD;
                end
            end

            S_RS_NX:
            begin
                if (!rd_used && comb_sz >= need_reg)
                begin
                    // Extend in place into the next block
                    if (comb_sz >= need_reg + SPLIT_W)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = to_idx(ptr_reg + need_reg + HDR_W);
                        wr_data    = pack_hdr(comb_sz - need_reg - HDR_W, 1'b0);
                        state_next = S_AL_W2;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data       = pack_hdr(comb_sz, 1'b1);
                        res_addr_next = blk_reg;
                        res_st_next   = ST_OK;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    mv_next    = 1'b1;
                    ptr_next   = HDR_W;
                    state_next = S_AL_RD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg[15:0];
                    out_st_next    = res_st_reg;
                    out_mv_next    = res_mv_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Every accepted item leaves idle at once
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // A granted block never has a null address
    a_ok_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (result_addr != 16'd0))
        else $error("ok result with null address");

    // A moved block is always a successful grant
    a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && moved) |-> (status == ST_OK))
        else $error("moved flag without ok status");

    // A result appears only out of the completion state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

endmodule

// File: test/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int unsigned HEAP_TOP   = 65536;
    localparam int unsigned NUM_HDR    = HEAP_TOP / GRAN_BYTES;
    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam int          NUM_RANDOM = 1400;
    localparam int          NUM_DIRECT = 22;

    typedef struct {
        logic [15:0] addr;
        logic [1:0]  st;
        logic        mv;
    } grant_t;

    typedef struct {
        logic [1:0]  m;
        logic [16:0] sz;
        logic [15:0] ad;
        bit          typed;
        logic [15:0] ea;
        logic [1:0]  es;
        logic        em;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [16:0] request_size;
    logic [15:0] block_addr;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result_addr;
    logic [1:0]  status;
    logic        moved;

    // heap image kept by the predictor
    int unsigned hdr_len [NUM_HDR];
    bit          hdr_busy [NUM_HDR];
    logic [15:0] live_q[$];
    grant_t      grant_q[$];

    int errors = 0;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int n_alloc, n_free, n_resize, n_moves, n_oom, n_checked;

    row_t dir_tab [NUM_DIRECT];

    first_fit_heap_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .request_size (request_size),
        .block_addr   (block_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_addr  (result_addr),
        .status       (status),
        .moved        (moved)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // header access by payload offset
    function automatic int unsigned hsize(int unsigned p);
        return hdr_len[(p - HDR_BYTES) >> 3];
    endfunction

    function automatic bit hused(int unsigned p);
        return hdr_busy[(p - HDR_BYTES) >> 3];
    endfunction

    function automatic void hset(int unsigned p, int unsigned sz, bit u);
        hdr_len[(p - HDR_BYTES) >> 3] = sz;
        hdr_busy[(p - HDR_BYTES) >> 3] = u;
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < NUM_HDR; i++)
        begin
            hdr_len[i] = 0;
            hdr_busy[i] = 0;
        end
        hset(HDR_BYTES, HEAP_TOP - HDR_BYTES, 1'b0);
    endfunction

    // walk blocks from the start, take the first free one that fits
    function automatic int unsigned first_fit(int unsigned req);
        int unsigned p;
        int unsigned bsz;
        int unsigned need;
        need = (req + 7) & ~32'd7;
        p = HDR_BYTES;
        while (p < HEAP_TOP)
        begin
            bsz = hsize(p);
            if (!hused(p) && bsz >= need)
            begin
                if (bsz >= need + HDR_BYTES + GRAN_BYTES)
                begin
                    hset(p + need + HDR_BYTES, bsz - need - HDR_BYTES, 1'b0);
                    hset(p, need, 1'b1);
                end
                else
                    hset(p, bsz, 1'b1);
                return p;
            end
            p += bsz + HDR_BYTES;
        end
        return 0;
    endfunction

    // clear used flag, merge forward only
    function automatic void release_block(int unsigned p);
        int unsigned sz;
        int unsigned nx;
        sz = hsize(p);
        nx = p + sz + HDR_BYTES;
        hset(p, sz, 1'b0);
        if (nx < HEAP_TOP && !hused(nx))
            hset(p, sz + HDR_BYTES + hsize(nx), 1'b0);
    endfunction

    function automatic bit addr_valid(int unsigned p);
        return p >= HDR_BYTES && p < HEAP_TOP && (p & 7) == 0;
    endfunction

    function automatic void drop_live(logic [15:0] a);
        for (int i = 0; i < live_q.size(); i++)
        begin
            if (live_q[i] == a)
            begin
                live_q.delete(i);
                return;
            end
        end
    endfunction

    // predict one request and update the heap image and live list
    function automatic grant_t heap_step(logic [1:0] m, logic [16:0] sz, logic [15:0] ad);
        grant_t g;
        int unsigned old;
        int unsigned nx;
        int unsigned need;
        int unsigned comb;
        int unsigned a;
        bit done;
        g.addr = 0;
        g.st = ST_NULL;
        g.mv = 1'b0;
        done = 1'b0;
        if (m == MODE_ALLOC || (m == MODE_RESIZE && ad == 0))
        begin
            if (sz != 0)
            begin
                a = first_fit(sz);
                g.addr = a[15:0];
                g.st = (a != 0) ? ST_OK : ST_OOM;
                if (a != 0)
                    live_q.push_back(a[15:0]);
            end
        end
        else if (m == MODE_FREE)
        begin
            if (addr_valid(ad))
            begin
                release_block(ad);
                drop_live(ad);
            end
        end
        else if (m == MODE_RESIZE)
        begin
            if (!addr_valid(ad))
                g.st = ST_OOM;
            else if (sz == 0)
            begin
                release_block(ad);
                drop_live(ad);
            end
            else
            begin
                old = hsize(ad);
                nx = ad + old + HDR_BYTES;
                need = (sz + 7) & ~32'd7;
                if (old >= sz)
                    done = 1'b1;
                else if (nx < HEAP_TOP && !hused(nx))
                begin
                    comb = old + HDR_BYTES + hsize(nx);
                    if (comb >= need)
                    begin
                        if (comb >= need + HDR_BYTES + GRAN_BYTES)
                        begin
                            hset(ad + need + HDR_BYTES, comb - need - HDR_BYTES, 1'b0);
                            hset(ad, need, 1'b1);
                        end
                        else
                            hset(ad, comb, 1'b1);
                        done = 1'b1;
                    end
                end
                if (done)
                begin
                    g.addr = ad;
                    g.st = ST_OK;
                end
                else
                begin
                    a = first_fit(sz);
                    g.addr = a[15:0];
                    if (a != 0)
                    begin
                        release_block(ad);
                        drop_live(ad);
                        live_q.push_back(a[15:0]);
                        g.st = ST_OK;
                        g.mv = 1'b1;
                    end
                    else
                        g.st = ST_OOM;
                end
            end
        end
        return g;
    endfunction

    // offer one item, wait for the handshake, then queue its expected result
    task automatic send_req(input logic [1:0] m, input logic [16:0] sz,
                            input logic [15:0] ad, input bit typed, input grant_t tg);
        grant_t g;
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        request_size <= sz;
        block_addr   <= ad;
        do
            @(posedge clk);
        while (in_stall);
        g = heap_step(m, sz, ad);
        if (g.st == ST_OOM)
            n_oom++;
        if (g.mv)
            n_moves++;
        if (m == MODE_ALLOC)
            n_alloc++;
        else if (m == MODE_FREE)
            n_free++;
        else if (m == MODE_RESIZE)
            n_resize++;
        grant_q.push_back(typed ? tg : g);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [16:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 17'($urandom_range(1, 128));
        else if (r < 90)
            return 17'($urandom_range(129, 2048));
        else if (r < 97)
            return 17'($urandom_range(2049, 65536));
        return 17'($urandom_range(65537, 131071));
    endfunction

    // one random item: mostly valid traffic on live blocks, some noise
    task automatic send_random();
        grant_t none;
        logic [15:0] la;
        int r;
        none = '{16'd0, ST_NULL, 1'b0};
        r = $urandom_range(99);
        if (live_q.size() > 0)
            la = live_q[$urandom_range(live_q.size() - 1)];
        if (live_q.size() > 60 && r < 45)
            r = 50;
        if (r < 45 || live_q.size() == 0 && r < 92)
            send_req(MODE_ALLOC, pick_size(), 16'($urandom), 1'b0, none);
        else if (r < 70)
            send_req(MODE_FREE, 17'($urandom), la, 1'b0, none);
        else if (r < 92)
            send_req(MODE_RESIZE, ($urandom_range(19) == 0) ? 17'd0 : pick_size(), la,
                     1'b0, none);
        else
        begin
            case ($urandom_range(4))
                0: send_req(MODE_SPARE, 17'($urandom), 16'($urandom), 1'b0, none);
                1: send_req(MODE_FREE, 17'($urandom), 16'($urandom) | 16'd1, 1'b0, none);
                2: send_req(MODE_RESIZE, pick_size(), 16'($urandom_range(1, 7)), 1'b0, none);
                3: send_req(MODE_RESIZE, pick_size(), 16'd0, 1'b0, none);
                default: send_req(MODE_ALLOC, 17'd0, 16'($urandom), 1'b0, none);
            endcase
        end
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        grant_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected result addr=%0d status=%0d moved=%0d",
                         $time, result_addr, status, moved);
                errors++;
            end
            else
            begin
                e = grant_q.pop_front();
                n_checked++;
                if (result_addr !== e.addr)
                begin
                    $display("%0t: result_addr expected %0d got %0d", $time, e.addr, result_addr);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, e.st, status);
                    errors++;
                end
                if (moved !== e.mv)
                begin
                    $display("%0t: moved expected %0d got %0d", $time, e.mv, moved);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #250ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        grant_t tg;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ALLOC;
        request_size = '0;
        block_addr = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        heap_clear();

        // directed walk from the reset heap
        dir_tab = '{
            '{MODE_ALLOC,  17'd0,      16'd0,     1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_ALLOC,  17'd65536,  16'd0,     1, 16'd0,  ST_OOM,  1'b0},
            '{MODE_ALLOC,  17'd65528,  16'd0,     1, 16'd8,  ST_OK,   1'b0},
            '{MODE_ALLOC,  17'd1,      16'd0,     1, 16'd0,  ST_OOM,  1'b0},
            '{MODE_FREE,   17'd0,      16'd8,     1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_ALLOC,  17'd1,      16'd0,     1, 16'd8,  ST_OK,   1'b0},
            '{MODE_ALLOC,  17'd100,    16'd0,     1, 16'd24, ST_OK,   1'b0},
            '{MODE_ALLOC,  17'd8,      16'd0,     0, 16'd0,  ST_OK,   1'b0},
            '{MODE_FREE,   17'd0,      16'd0,     1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_FREE,   17'd0,      16'd3,     1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_FREE,   17'd0,      16'hFFFF,  1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_RESIZE, 17'd16,     16'd0,     0, 16'd0,  ST_OK,   1'b0},
            '{MODE_RESIZE, 17'd5,      16'hFFFF,  1, 16'd0,  ST_OOM,  1'b0},
            '{MODE_RESIZE, 17'd5,      16'd4,     1, 16'd0,  ST_OOM,  1'b0},
            '{MODE_RESIZE, 17'd8,      16'd8,     1, 16'd8,  ST_OK,   1'b0},
            '{MODE_RESIZE, 17'd65536,  16'd24,    1, 16'd0,  ST_OOM,  1'b0},
            '{MODE_FREE,   17'd0,      16'd136,   1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_RESIZE, 17'd112,    16'd24,    0, 16'd0,  ST_OK,   1'b0},
            '{MODE_RESIZE, 17'd200,    16'd8,     0, 16'd0,  ST_OK,   1'b0},
            '{MODE_RESIZE, 17'd0,      16'd152,   1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_SPARE,  17'h1FFFF,  16'hFFFF,  1, 16'd0,  ST_NULL, 1'b0},
            '{MODE_ALLOC,  17'h1FFFF,  16'd0,     1, 16'd0,  ST_OOM,  1'b0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            tg = '{dir_tab[i].ea, dir_tab[i].es, dir_tab[i].em};
            send_req(dir_tab[i].m, dir_tab[i].sz, dir_tab[i].ad, dir_tab[i].typed, tg);
        end

        // random traffic in four phases: none, sender idling, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 34 : 0;
            recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 34 : 0;
            for (int k = 0; k < NUM_RANDOM / 4; k++)
            begin
                if (ph == 0 && k == 100)
                    hold_req = 1'b1;
                if (ph == 2 && k == 150)
                begin
                    // pause the sender until everything has drained
                    drop_valid();
                    while (grant_q.size() != 0)
                        @(posedge clk);
                end
                send_random();
            end
        end
        drop_valid();

        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Checked %0d results: %0d alloc, %0d free, %0d resize, %0d moves, %0d out of memory",
                 n_checked, n_alloc, n_free, n_resize, n_moves, n_oom);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
